// File: src/wav_pkg.sv
// Shared types and constants for the WAV header chunk parser.
`timescale 1ns / 1ps
`default_nettype none
package wav_pkg;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_HDR = 2'd1;
    localparam logic [1:0] ST_NO_DATA = 2'd2;
    localparam logic [1:0] ST_ZERO    = 2'd3;

    localparam logic [31:0] TAG_RIFF = 32'h46464952;
    localparam logic [31:0] TAG_WAVE = 32'h45564157;
    localparam logic [31:0] TAG_FMT  = 32'h20746D66;
    localparam logic [31:0] TAG_DATA = 32'h61746164;

    typedef struct packed {
        logic [1:0]   status;
        logic [127:0] fmt;
        logic [31:0]  offset;
        logic [31:0]  size;
    } t_job;
endpackage
`default_nettype wire

// File: src/wav_front.sv
// Byte-serial front end: walks the RIFF chunks and produces one job per file.
`timescale 1ns / 1ps
`default_nettype none
module wav_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    output wav_pkg::t_job    o_job,
    output logic             o_job_valid
);
    localparam logic [2:0] PH_HEADER = 3'd0, PH_TAG = 3'd1, PH_SZ_FMT = 3'd2,
                           PH_SZ_DATA = 3'd3, PH_SZ_SKIP = 3'd4, PH_FMT = 3'd5,
                           PH_SKIP = 3'd6, PH_DONE = 3'd7;

    logic [2:0]   r_phase, n_phase;
    logic [31:0]  r_pos;
    logic [3:0]   r_cnt, n_cnt;
    logic [31:0]  r_shift;
    logic [31:0]  r_skip, n_skip;
    logic         r_hok, n_hok;
    logic [127:0] r_fmt, n_fmt;
    logic [31:0]  acc;
    logic         emit;
    wav_pkg::t_job job;

    assign acc = {i_byte, r_shift[31:8]};

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt + 4'd1;
        n_skip  = r_skip;
        n_hok   = r_hok;
        n_fmt   = r_fmt;
        emit    = 1'b0;
        job     = '0;
        unique case (r_phase)
            PH_HEADER: begin
                if (r_cnt == 4'd3 && acc != wav_pkg::TAG_RIFF) n_hok = 1'b0;
                if (r_cnt == 4'd11) begin
                    n_cnt = '0;
                    if (acc != wav_pkg::TAG_WAVE || !n_hok) begin
                        n_hok = 1'b0;
                        emit = 1'b1;
                        job.status = wav_pkg::ST_BAD_HDR;
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_TAG;
                    end
                end
            end
            PH_TAG, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_SKIP: begin
                if (r_cnt == 4'd3) begin
                    n_cnt = '0;
                    priority if (r_phase == PH_TAG) begin
                        n_phase = (acc == wav_pkg::TAG_FMT) ? PH_SZ_FMT :
                                  (acc == wav_pkg::TAG_DATA) ? PH_SZ_DATA : PH_SZ_SKIP;
                    end else if (r_phase == PH_SZ_FMT) begin
                        n_skip = (acc > 32'd16) ? acc - 32'd16 : '0;
                        n_phase = PH_FMT;
                    end else if (r_phase == PH_SZ_DATA) begin
                        emit = 1'b1;
                        job.status = wav_pkg::ST_OK;
                        job.fmt = r_fmt;
                        job.offset = r_pos + 32'd1;
                        job.size = acc;
                        n_phase = PH_DONE;
                    end else begin
                        n_skip = acc;
                        n_phase = (acc != '0) ? PH_SKIP : PH_TAG;
                    end
                end
            end
            PH_FMT: begin
                n_fmt[r_cnt*8 +: 8] = i_byte;
                if (r_cnt == 4'd15) begin
                    n_cnt = '0;
                    n_phase = (r_skip != '0) ? PH_SKIP : PH_TAG;
                end
            end
            PH_SKIP: begin
                n_cnt = r_cnt;
                n_skip = r_skip - 32'd1;
                if (n_skip == '0) n_phase = PH_TAG;
            end
            default: n_cnt = r_cnt;
        endcase
        if (i_last && !emit && n_phase != PH_DONE) begin
            emit = 1'b1;
            job = '0;
            job.status = (n_phase == PH_HEADER) ? wav_pkg::ST_BAD_HDR : wav_pkg::ST_NO_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos <= '0;
            r_cnt <= '0;
            r_shift <= '0;
            r_skip <= '0;
            r_hok <= 1'b1;
            r_fmt <= '0;
            o_job_valid <= 1'b0;
        end else begin
            o_job_valid <= i_valid && emit;
            if (i_valid) begin
                o_job <= job;
                if (i_last) begin
                    r_phase <= PH_HEADER;
                    r_pos <= '0;
                    r_cnt <= '0;
                    r_shift <= '0;
                    r_skip <= '0;
                    r_hok <= 1'b1;
                    r_fmt <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_pos <= r_pos + 32'd1;
                    r_cnt <= n_cnt;
                    if (r_phase != PH_FMT && r_phase != PH_SKIP && r_phase != PH_DONE)
                        r_shift <= acc;
                    r_skip <= n_skip;
                    r_hok <= n_hok;
                    r_fmt <= n_fmt;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: src/wav_divider.sv
// Radix-2 restoring divider for 64-bit dividends and 32-bit divisors.
`timescale 1ns / 1ps
`default_nettype none
module wav_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic [63:0]      o_quot,
    output logic             o_busy
);
    logic [63:0] r_quot;
    logic [32:0] r_rem;
    logic [6:0]  r_cnt;
    logic [31:0] r_den;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted = {r_rem[31:0], r_quot[63]};
    assign trial = shifted - {1'b0, r_den};
    assign o_quot = r_quot;
    assign o_busy = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_quot <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= 7'd64;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 7'd1;
            if (!trial[32]) begin
                r_rem <= trial;
                r_quot <= {r_quot[62:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quot <= {r_quot[62:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// File: src/wav_back.sv
// Back end: runs the duration and sample-count divisions and holds the result.
`timescale 1ns / 1ps
`default_nettype none
module wav_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire wav_pkg::t_job i_job,
    output logic               o_job_ready,
    output logic               o_res_valid,
    input  wire logic          i_res_pop,
    output wav_pkg::t_job      o_res,
    output logic [31:0]        o_ms,
    output logic [31:0]        o_samples
);
    localparam logic [2:0] S_IDLE = 3'd0, S_DIV1 = 3'd1, S_DIV2 = 3'd2,
                           S_DIV3 = 3'd3, S_OUT = 3'd4;
    logic [2:0]    r_state;
    logic          r_wait;
    logic          start;
    logic [63:0]   num;
    logic [31:0]   den;
    logic [63:0]   quot;
    logic          busy;
    logic [31:0]   ch, rate, bits;
    wav_pkg::t_job n_res;

    assign ch   = {16'd0, o_res.fmt[31:16]};
    assign rate = o_res.fmt[95:64];
    assign bits = {16'd0, o_res.fmt[127:112]};

    wav_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_num(num), .i_den(den), .o_quot(quot), .o_busy(busy)
    );

    assign o_job_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);

    always_comb begin
        n_res = i_job;
        if (i_job.status == wav_pkg::ST_OK && (i_job.fmt[95:64] == '0
                || i_job.fmt[31:16] == '0 || i_job.fmt[127:112] == '0)) begin
            n_res.status = wav_pkg::ST_ZERO;
        end
    end

    always_comb begin
        start = 1'b0;
        num = '0;
        den = rate;
        unique case (r_state)
            S_DIV1: begin
                start = !busy && !r_wait;
                num = {32'd0, o_res.size} * 64'd1000;
            end
            S_DIV2: begin
                start = !busy && !r_wait;
                den = ch;
                num = {32'd0, o_res.size};
            end
            S_DIV3: begin
                start = !busy && !r_wait;
                den = bits;
                num = {32'd0, o_samples};
            end
            default: start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_job_valid) begin
                    o_res <= n_res;
                    o_ms <= '0;
                    o_samples <= '0;
                    r_state <= (n_res.status == wav_pkg::ST_OK) ? S_DIV1 : S_OUT;
                end
                S_DIV1: if (r_wait && !busy) begin
                    o_ms <= (quot[63:32] != '0) ? 32'hFFFF_FFFF : quot[31:0];
                    r_state <= S_DIV2;
                end
                S_DIV2: if (r_wait && !busy) begin
                    o_samples <= {quot[28:0], 3'b000};
                    r_state <= S_DIV3;
                end
                S_DIV3: if (r_wait && !busy) begin
                    o_samples <= quot[31:0];
                    r_state <= S_OUT;
                end
                S_OUT: if (i_res_pop) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wait <= 1'b0;
        else if (start) r_wait <= 1'b1;
        else if (r_wait && !busy) r_wait <= 1'b0;
    end
endmodule
`default_nettype wire

// File: src/wav_header_chunk_parser_core.sv
// Top level of the WAV header chunk parser.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one file byte per cycle while full is low and emits one result
// per file. Three 64-step divisions share one restoring divider. A
// two-entry queue between the byte parser and the divider lets the next
// file stream in while results wait to be popped; full rises when that
// queue has no room, a job just leaving the front end counted as taking one.
module wav_header_chunk_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_file_byte,
    input  wire logic        i_is_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_status,
    output logic [15:0]      o_format_tag,
    output logic [15:0]      o_channel_count,
    output logic [31:0]      o_sample_rate,
    output logic [31:0]      o_byte_rate,
    output logic [15:0]      o_block_align,
    output logic [15:0]      o_sample_bits,
    output logic [31:0]      o_payload_offset,
    output logic [31:0]      o_payload_size,
    output logic [31:0]      o_total_ms,
    output logic [31:0]      o_total_samples
);
    wav_pkg::t_job job, q_head, res;
    logic          job_valid, back_ready, res_valid, acc_in;
    wav_pkg::t_job r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    // Count the job that may be in flight in the front end as taking a slot.
    assign full = (r_cnt == 2'd2) || (r_cnt == 2'd1 && job_valid);
    assign acc_in = push && !full;

    wav_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc_in), .i_byte(i_file_byte),
        .i_last(i_is_last), .o_job(job), .o_job_valid(job_valid)
    );

    assign q_head = r_q[r_rp];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (job_valid) begin
                r_q[r_wp] <= job;
                r_wp <= ~r_wp;
            end
            if (r_cnt != '0 && back_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, job_valid} - {1'b0, (r_cnt != '0 && back_ready)};
        end
    end

    wav_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(r_cnt != '0), .i_job(q_head),
        .o_job_ready(back_ready), .o_res_valid(res_valid), .i_res_pop(pop),
        .o_res(res), .o_ms(o_total_ms), .o_samples(o_total_samples)
    );

    assign empty = !res_valid;
    assign o_status = res.status;
    assign o_format_tag = res.fmt[15:0];
    assign o_channel_count = res.fmt[31:16];
    assign o_sample_rate = res.fmt[63:32];
    assign o_byte_rate = res.fmt[95:64];
    assign o_block_align = res.fmt[111:96];
    assign o_sample_bits = res.fmt[127:112];
    assign o_payload_offset = res.offset;
    assign o_payload_size = res.size;

    a_qcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("job queue overflow");
    a_nojob_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !job_valid) else $error("job lost");
endmodule
`default_nettype wire

// File: sim/tb_wav_header_chunk_parser_core.sv
// Self-checking testbench for the WAV header chunk parser, using directed files and random byte streams.
`timescale 1ns / 1ps
`default_nettype none
module tb_wav_header_chunk_parser_core;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] payload_offset;
        logic [31:0] payload_size;
        logic [31:0] total_ms;
        logic [31:0] total_samples;
    } t_info;

    typedef enum logic [2:0] {
        P_HEADER, P_TAG, P_SZ_FMT, P_SZ_DATA, P_SZ_SKIP, P_FMT, P_SKIP, P_DONE
    } t_phase;

    typedef struct {
        logic [7:0] file_byte;
        logic       is_last;
        logic       has_exp;
        t_info      exp_info;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  i_file_byte = 8'd0;
    logic        i_is_last = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  o_status;
    logic [15:0] o_format_tag;
    logic [15:0] o_channel_count;
    logic [31:0] o_sample_rate;
    logic [31:0] o_byte_rate;
    logic [15:0] o_block_align;
    logic [15:0] o_sample_bits;
    logic [31:0] o_payload_offset;
    logic [31:0] o_payload_size;
    logic [31:0] o_total_ms;
    logic [31:0] o_total_samples;

    wav_header_chunk_parser_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_file_byte(i_file_byte), .i_is_last(i_is_last), .empty(empty), .pop(pop),
        .o_status(o_status), .o_format_tag(o_format_tag),
        .o_channel_count(o_channel_count), .o_sample_rate(o_sample_rate),
        .o_byte_rate(o_byte_rate), .o_block_align(o_block_align),
        .o_sample_bits(o_sample_bits), .o_payload_offset(o_payload_offset),
        .o_payload_size(o_payload_size), .o_total_ms(o_total_ms),
        .o_total_samples(o_total_samples)
    );

    always #5 i_clk = ~i_clk;

    t_phase      ph;
    logic [31:0] pos, cnt, shreg, skip_left, data_size;
    logic        hdr_good;
    logic [7:0]  fmt_bytes [16];

    t_info       info_queue [$];
    t_row        dir_rows [$];
    byte         file_buf [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          files_sent = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_recv = 1'b0;
    bit          stim_done = 1'b0;
    int          phase_idle [4] = '{0, 68, 0, 15};
    int          phase_stall [4] = '{0, 0, 68, 15};

    function automatic logic [15:0] fmt16(int i);
        return {fmt_bytes[(i + 1) & 15], fmt_bytes[i & 15]};
    endfunction

    function automatic logic [31:0] fmt32(int i);
        return {fmt16(i + 2), fmt16(i)};
    endfunction

    task automatic parser_clear();
        ph = P_HEADER; pos = 0; cnt = 0; shreg = 0; skip_left = 0;
        hdr_good = 1'b1; data_size = 0;
        for (int i = 0; i < 16; i++) fmt_bytes[i] = 8'd0;
    endtask

    function automatic t_info error_info(logic [1:0] code);
        t_info r;
        r = '0;
        r.status = code;
        return r;
    endfunction

    function automatic t_info data_info(logic [31:0] offs);
        t_info r;
        logic [63:0] ms;
        logic [31:0] per_ch;
        r = '0;
        r.format_tag = fmt16(0);
        r.channel_count = fmt16(2);
        r.sample_rate = fmt32(4);
        r.byte_rate = fmt32(8);
        r.block_align = fmt16(12);
        r.sample_bits = fmt16(14);
        r.payload_offset = offs;
        r.payload_size = data_size;
        if (r.byte_rate == 0 || r.channel_count == 0 || r.sample_bits == 0) begin
            r.status = wav_pkg::ST_ZERO;
        end else begin
            r.status = wav_pkg::ST_OK;
            ms = ({32'd0, data_size} * 64'd1000) / {32'd0, r.byte_rate};
            r.total_ms = (ms > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ms[31:0];
            per_ch = (data_size / {16'd0, r.channel_count}) * 32'd8;
            r.total_samples = per_ch / {16'd0, r.sample_bits};
        end
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last, output bit got,
                              output t_info r);
        logic [31:0] acc;
        got = 1'b0;
        r = '0;
        acc = (shreg >> 8) | ({24'd0, b} << 24);
        case (ph)
            P_HEADER: begin
                shreg = acc;
                if (cnt == 3 && acc != wav_pkg::TAG_RIFF) hdr_good = 1'b0;
                if (cnt == 11) begin
                    if (acc != wav_pkg::TAG_WAVE) hdr_good = 1'b0;
                    if (!hdr_good) begin
                        r = error_info(wav_pkg::ST_BAD_HDR); got = 1'b1; ph = P_DONE;
                    end else begin
                        ph = P_TAG;
                    end
                    cnt = 0;
                end else begin
                    cnt++;
                end
            end
            P_TAG, P_SZ_FMT, P_SZ_DATA, P_SZ_SKIP: begin
                shreg = acc;
                if (cnt < 3) begin
                    cnt++;
                end else begin
                    cnt = 0;
                    if (ph == P_TAG) begin
                        ph = (acc == wav_pkg::TAG_FMT) ? P_SZ_FMT :
                             (acc == wav_pkg::TAG_DATA) ? P_SZ_DATA : P_SZ_SKIP;
                    end else if (ph == P_SZ_FMT) begin
                        skip_left = (acc > 16) ? acc - 16 : 0;
                        ph = P_FMT;
                    end else if (ph == P_SZ_DATA) begin
                        data_size = acc;
                        r = data_info(pos + 1); got = 1'b1; ph = P_DONE;
                    end else begin
                        skip_left = acc;
                        ph = (acc != 0) ? P_SKIP : P_TAG;
                    end
                end
            end
            P_FMT: begin
                fmt_bytes[cnt & 15] = b;
                if (cnt >= 15) begin
                    cnt = 0;
                    ph = (skip_left != 0) ? P_SKIP : P_TAG;
                end else begin
                    cnt++;
                end
            end
            P_SKIP: begin
                skip_left--;
                if (skip_left == 0) ph = P_TAG;
            end
            default: ;
        endcase
        pos++;
        if (last) begin
            if (!got && ph != P_DONE) begin
                r = error_info(ph == P_HEADER ? wav_pkg::ST_BAD_HDR : wav_pkg::ST_NO_DATA);
                got = 1'b1;
            end
            parser_clear();
        end
    endtask

    task automatic put32(logic [31:0] v);
        for (int i = 0; i < 4; i++) file_buf.push_back(v[8*i +: 8]);
    endtask

    task automatic put16(logic [15:0] v);
        file_buf.push_back(v[7:0]);
        file_buf.push_back(v[15:8]);
    endtask

    function automatic logic [31:0] rnd_small32();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic build_random_file();
        int n_chunks;
        int sel;
        int len;
        file_buf.delete();
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) file_buf.push_back($urandom);
            return;
        end
        put32(sel < 12 ? $urandom : wav_pkg::TAG_RIFF);
        put32($urandom);
        put32(sel >= 12 && sel < 15 ? $urandom : wav_pkg::TAG_WAVE);
        n_chunks = $urandom_range(0, 3);
        for (int c = 0; c < n_chunks; c++) begin
            if ($urandom_range(0, 3) != 0) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 24) : 16;
                put32(wav_pkg::TAG_FMT);
                put32(len);
                put16($urandom_range(0, 5) == 0 ? 16'hFFFF : $urandom_range(0, 3));
                put16($urandom_range(0, 7) == 0 ? 16'd0 : $urandom_range(1, 8));
                put32(rnd_small32());
                put32($urandom_range(0, 7) == 0 ? 32'd0 : rnd_small32());
                put16($urandom);
                put16($urandom_range(0, 7) == 0 ? 16'd0 : $urandom_range(1, 32));
                for (int i = 16; i < len; i++) file_buf.push_back($urandom);
            end else begin
                len = $urandom_range(0, 10);
                put32($urandom);
                put32(len);
                for (int i = 0; i < len; i++) file_buf.push_back($urandom);
            end
        end
        if (sel < 90) begin
            put32(wav_pkg::TAG_DATA);
            put32(rnd_small32());
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) file_buf.push_back($urandom);
        end else begin
            len = $urandom_range(0, 4);
            for (int i = 0; i < len; i++) file_buf.push_back($urandom);
        end
    endtask

    task automatic add_row(logic [7:0] b, logic last, logic has, t_info e);
        t_row r;
        r.file_byte = b; r.is_last = last; r.has_exp = has; r.exp_info = e;
        dir_rows.push_back(r);
    endtask

    task automatic send_byte(logic [7:0] b, logic last, logic has_typed, t_info typed);
        bit got;
        t_info r;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_file_byte <= b;
        i_is_last <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        parse_byte(b, last, got, r);
        if (has_typed && (!got || typed != r)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row disagrees with predictor: %h vs %h", typed, r);
        end
        if (got) info_queue.push_back(r);
        if (last) files_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_buf.size(); i++)
            send_byte(file_buf[i], i == file_buf.size() - 1, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        t_info got_info, want;
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (cycles > 2000000) begin
                $display("FAIL wav_header_chunk_parser_core");
                $finish;
            end
            if (pop && !empty) begin
                got_info = '{o_status, o_format_tag, o_channel_count, o_sample_rate,
                             o_byte_rate, o_block_align, o_sample_bits, o_payload_offset,
                             o_payload_size, o_total_ms, o_total_samples};
                results_seen <= results_seen + 1;
                if (info_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got_info);
                end else begin
                    want = info_queue.pop_front();
                    if (want != got_info) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h got %h", want, got_info);
                    end
                end
            end
            pop <= !hold_recv && !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial begin
        t_info e;
        parser_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bad first magic, a truncated header, a header that ends without data,
        // and a data chunk with no fmt chunk.
        e = error_info(wav_pkg::ST_BAD_HDR);
        for (int i = 0; i < 12; i++) add_row(8'h00, 1'b0, i == 11, e);
        add_row(8'hFF, 1'b1, 1'b0, e);
        file_buf.delete(); put32(wav_pkg::TAG_RIFF);
        for (int i = 0; i < 3; i++) add_row(file_buf[i], i == 2, i == 2, e);
        file_buf.delete(); put32(wav_pkg::TAG_RIFF); put32(32'hFFFF_FFFF);
        put32(wav_pkg::TAG_WAVE);
        for (int i = 0; i < 12; i++)
            add_row(file_buf[i], i == 11, i == 11, error_info(wav_pkg::ST_NO_DATA));
        file_buf.delete(); put32(wav_pkg::TAG_RIFF); put32(0); put32(wav_pkg::TAG_WAVE);
        put32(wav_pkg::TAG_DATA); put32(32'hFFFF_FFFF);
        e = '0; e.status = wav_pkg::ST_ZERO; e.payload_offset = 20;
        e.payload_size = 32'hFFFF_FFFF;
        for (int i = 0; i < 20; i++) add_row(file_buf[i], i == 19, i == 19, e);
        foreach (dir_rows[k])
            send_byte(dir_rows[k].file_byte, dir_rows[k].is_last, dir_rows[k].has_exp,
                      dir_rows[k].exp_info);

        // Full-scale format fields, a saturated play time and a short fmt chunk.
        file_buf.delete(); put32(wav_pkg::TAG_RIFF); put32(0); put32(wav_pkg::TAG_WAVE);
        put32(wav_pkg::TAG_FMT); put32(16);
        put16(16'hFFFF); put16(16'd1); put32(32'hFFFF_FFFF); put32(32'd1);
        put16(16'hFFFF); put16(16'd1); put32(wav_pkg::TAG_DATA); put32(32'hFFFF_FFFF);
        send_file();
        file_buf.delete(); put32(wav_pkg::TAG_RIFF); put32(0); put32(wav_pkg::TAG_WAVE);
        put32(wav_pkg::TAG_FMT); put32(4); put32(wav_pkg::TAG_DATA); put32(32'h1234);
        for (int i = 0; i < 8; i++) file_buf.push_back(8'h80);
        put32(wav_pkg::TAG_DATA); put32(32'h10);
        file_buf.push_back(8'hAA);
        send_file();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int f = 0; f < 5; f++) begin
                build_random_file();
                send_file();
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_recv = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            begin
                for (int f = 0; f < 6; f++) begin
                    build_random_file();
                    send_file();
                end
                push <= 1'b0;
            end
        join
        stim_done = 1'b1;
        wait (info_queue.size() == 0);
        repeat (400) @(posedge i_clk);
        $display("Sent %0d files through four handshake phases and a long receiver hold-off.",
                 files_sent);
        $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && info_queue.size() == 0) begin
            $display("PASS wav_header_chunk_parser_core");
        end else begin
            $display("FAIL wav_header_chunk_parser_core");
        end
        $finish;
    end
endmodule
`default_nettype wire
